// ===== sv/lla_pkg.sv =====
package lla_pkg;

   // operation codes of a request transaction
   localparam logic [1:0] OP_SET     = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // register indexes on the configuration port
   localparam logic [1:0] REG_BIRTH_MASK    = 2'd0;
   localparam logic [1:0] REG_SURVIVAL_MASK = 2'd1;
   localparam logic [1:0] REG_ROWS_IN_USE   = 2'd2;
   localparam logic [1:0] REG_COLS_IN_USE   = 2'd3;

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [8:0] birth_mask;
      logic [8:0] survival_mask;
      logic [6:0] rows_in_use;
      logic [6:0] cols_in_use;
   } cfg_type;

   // source of the grid read address
   typedef enum logic [2:0] {
      RD_NONE   = 3'd0,
      RD_COORD  = 3'd1,
      RD_LAST   = 3'd2,
      RD_FIRST  = 3'd3,
      RD_SECOND = 3'd4,
      RD_AHEAD  = 3'd5
   } rd_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      rd_sel_type rd_sel;
      logic       latch_req;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       wr_zero;
      logic       flag_range;
      logic       cell_finish;
      logic       load_prev;
      logic       load_first;
      logic       row_step;
      logic       rsp_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic in_range;
      logic row_last;
      logic zero_last;
      logic rows_full;
      logic rsp_free;
   } stat_type;

endpackage

// ===== sv/lla_csr.sv =====
module lla_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lla_pkg::PADDR_W-1:0]  paddr,
   input  logic [lla_pkg::PDATA_W-1:0]  pwdata,
   output logic [lla_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output lla_pkg::cfg_type             cfg
);

   logic [8:0] birth_mask_ff;
   logic [8:0] survival_mask_ff;
   logic [6:0] rows_in_use_ff;
   logic [6:0] cols_in_use_ff;
   logic [1:0] reg_index;
   logic       wr_strobe;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_strobe = psel & penable & pwrite;

   // register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         birth_mask_ff    <= 9'd8;
         survival_mask_ff <= 9'd12;
         rows_in_use_ff   <= 7'd64;
         cols_in_use_ff   <= 7'd64;
      end else if (wr_strobe) begin
         case (reg_index)
            lla_pkg::REG_BIRTH_MASK:    birth_mask_ff    <= pwdata[8:0];
            lla_pkg::REG_SURVIVAL_MASK: survival_mask_ff <= pwdata[8:0];
            lla_pkg::REG_ROWS_IN_USE:   rows_in_use_ff   <= pwdata[6:0];
            lla_pkg::REG_COLS_IN_USE:   cols_in_use_ff   <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (reg_index)
         lla_pkg::REG_BIRTH_MASK:    prdata = {23'd0, birth_mask_ff};
         lla_pkg::REG_SURVIVAL_MASK: prdata = {23'd0, survival_mask_ff};
         lla_pkg::REG_ROWS_IN_USE:   prdata = {25'd0, rows_in_use_ff};
         lla_pkg::REG_COLS_IN_USE:   prdata = {25'd0, cols_in_use_ff};
         default:                    prdata = '0;
      endcase
   end

   assign cfg.birth_mask    = birth_mask_ff;
   assign cfg.survival_mask = survival_mask_ff;
   assign cfg.rows_in_use   = rows_in_use_ff;
   assign cfg.cols_in_use   = cols_in_use_ff;

endmodule

// ===== sv/lla_datapath.sv =====
module lla_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  lla_pkg::cfg_type  cfg,
   input  logic [1:0]        req_op,
   input  logic [5:0]        req_row,
   input  logic [5:0]        req_col,
   input  lla_pkg::cmd_type  cmd,
   output lla_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_cell_alive,
   output logic              rsp_status
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int RW = ((CW > 7) ? CW : 7) + 1;

   logic [MAX_COLS-1:0] grid_ff [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_data_ff;
   logic [MAX_COLS-1:0] prev_ff;
   logic [MAX_COLS-1:0] mid_ff;
   logic [MAX_COLS-1:0] first_ff;
   logic [RW-1:0]       cnt_ff;
   logic [1:0]          req_op_ff;
   logic [5:0]          req_row_ff;
   logic [5:0]          req_col_ff;
   logic                res_alive_ff;
   logic                res_status_ff;
   logic                rsp_valid_ff;
   logic                rsp_alive_ff;
   logic                rsp_status_ff;

   logic [RW-1:0]       rows_ext;
   logic [RW-1:0]       nrows;
   logic [6:0]          ncols;
   logic [RW-1:0]       coord_rw;
   logic [RW-1:0]       rd_addr_rw;
   logic                rd_en;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [MAX_COLS-1:0] wr_data;
   logic [MAX_COLS-1:0] col_onehot;
   logic [MAX_COLS-1:0] down_row;
   logic [MAX_COLS-1:0] fresh;
   logic                cell_bit;

   // grid size saturated to the storage
   assign rows_ext = RW'(cfg.rows_in_use);
   assign nrows = (rows_ext == '0) ? RW'(1) :
                  ((rows_ext > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : rows_ext);
   assign ncols = (cfg.cols_in_use == 7'd0) ? 7'd1 :
                  ((cfg.cols_in_use > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.cols_in_use);

   assign coord_rw = RW'(req_row_ff);

   // status towards the controller
   assign stat.in_range  = (coord_rw < nrows) && ({1'b0, req_col_ff} < ncols);
   assign stat.row_last  = (cnt_ff == nrows - RW'(1));
   assign stat.zero_last = (cnt_ff == RW'(MAX_ROWS - 1));
   assign stat.rows_full = (nrows == RW'(MAX_ROWS));
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // read address, suppressed beyond the rows in use
   always_comb begin
      case (cmd.rd_sel)
         lla_pkg::RD_COORD:  rd_addr_rw = coord_rw;
         lla_pkg::RD_LAST:   rd_addr_rw = nrows - RW'(1);
         lla_pkg::RD_FIRST:  rd_addr_rw = '0;
         lla_pkg::RD_SECOND: rd_addr_rw = RW'(1);
         lla_pkg::RD_AHEAD:  rd_addr_rw = cnt_ff + RW'(2);
         default:            rd_addr_rw = '0;
      endcase
   end
   assign rd_en = (cmd.rd_sel != lla_pkg::RD_NONE) && (rd_addr_rw < nrows);

   // column select for set and read
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_onehot[c] = (6'(c) == req_col_ff);
      end
   end
   assign cell_bit = |(rd_data_ff & col_onehot);

   // row below: original next row, or the saved first row at the wrap
   assign down_row = ((cnt_ff + RW'(1)) < nrows) ? rd_data_ff : first_ff;

   // next generation of one row, every column in parallel
   always_comb begin
      logic [2*MAX_COLS-1:0] up2;
      logic [2*MAX_COLS-1:0] mid2;
      logic [2*MAX_COLS-1:0] dn2;
      logic                  up_last;
      logic                  mid_last;
      logic                  dn_last;
      logic                  ul, ur, ml, mr, dl, dr;
      logic [3:0]            count;
      logic [8:0]            mask;
      up2      = {prev_ff, prev_ff};
      mid2     = {mid_ff, mid_ff};
      dn2      = {down_row, down_row};
      up_last  = 1'b0;
      mid_last = 1'b0;
      dn_last  = 1'b0;
      for (int c = 0; c < MAX_COLS; c++) begin
         if (7'(c) == ncols - 7'd1) begin
            up_last  = prev_ff[c];
            mid_last = mid_ff[c];
            dn_last  = down_row[c];
         end
      end
      for (int c = 0; c < MAX_COLS; c++) begin
         // left neighbour wraps to the last column in use
         if (c == 0) begin
            ul = up_last;
            ml = mid_last;
            dl = dn_last;
         end else begin
            ul = up2[c+MAX_COLS-1];
            ml = mid2[c+MAX_COLS-1];
            dl = dn2[c+MAX_COLS-1];
         end
         // right neighbour wraps to column zero
         if (7'(c) + 7'd1 == ncols) begin
            ur = prev_ff[0];
            mr = mid_ff[0];
            dr = down_row[0];
         end else begin
            ur = up2[c+1];
            mr = mid2[c+1];
            dr = dn2[c+1];
         end
         count = {3'd0, ul} + {3'd0, prev_ff[c]} + {3'd0, ur} + {3'd0, ml}
               + {3'd0, mr} + {3'd0, dl} + {3'd0, down_row[c]} + {3'd0, dr};
         mask = mid_ff[c] ? cfg.survival_mask : cfg.birth_mask;
         fresh[c] = (7'(c) < ncols) && mask[count];
      end
   end

   // grid write source
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = '0;
      if (cmd.wr_zero) begin
         wr_en = 1'b1;
      end else if (cmd.row_step) begin
         wr_en   = 1'b1;
         wr_data = fresh;
      end else if (cmd.cell_finish && (req_op_ff == lla_pkg::OP_SET)) begin
         wr_en   = 1'b1;
         wr_addr = coord_rw[AW-1:0];
         wr_data = rd_data_ff | col_onehot;
      end
   end

   // grid memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= grid_ff[rd_addr_rw[AW-1:0]];
      end
   end

   // row copies for the generation pass
   always_ff @(posedge clock) begin
      if (cmd.load_prev) begin
         prev_ff <= rd_data_ff;
      end else if (cmd.row_step) begin
         prev_ff <= mid_ff;
      end
      if (cmd.load_first) begin
         first_ff <= rd_data_ff;
         mid_ff   <= rd_data_ff;
      end else if (cmd.row_step) begin
         mid_ff <= down_row;
      end
   end

   // row counter
   always_ff @(posedge clock) begin
      if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + RW'(1);
      end
   end

   // captured request and pending result
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_op_ff     <= req_op;
         req_row_ff    <= req_row;
         req_col_ff    <= req_col;
         res_alive_ff  <= 1'b0;
         res_status_ff <= 1'b0;
      end else begin
         if (cmd.flag_range) begin
            res_status_ff <= 1'b1;
         end
         if (cmd.cell_finish && (req_op_ff == lla_pkg::OP_READ)) begin
            res_alive_ff <= cell_bit;
         end
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_alive_ff  <= res_alive_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_alive = rsp_alive_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ===== sv/lla_ctrl.sv =====
module lla_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  lla_pkg::stat_type stat,
   output lla_pkg::cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE       = 10'b00_0000_0001,
      S_ZERO_START = 10'b00_0000_0010,
      S_ZERO       = 10'b00_0000_0100,
      S_CELL_RD    = 10'b00_0000_1000,
      S_CELL_WR    = 10'b00_0001_0000,
      S_ADV_LAST   = 10'b00_0010_0000,
      S_ADV_FIRST  = 10'b00_0100_0000,
      S_ADV_PRIME  = 10'b00_1000_0000,
      S_ADV_ROW    = 10'b01_0000_0000,
      S_DONE       = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.cnt_clear = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               reply_in      = 1'b1;
               case (req_op)
                  lla_pkg::OP_SET,
                  lla_pkg::OP_READ:    state_in = S_CELL_RD;
                  lla_pkg::OP_ADVANCE: state_in = S_ADV_LAST;
                  lla_pkg::OP_CLEAR:   state_in = S_ZERO;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_ZERO_START: begin
            cmd.cnt_clear = 1'b1;
            state_in      = S_ZERO;
         end
         S_ZERO: begin
            // one row of zeros per cycle up to the end of storage
            cmd.wr_zero = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.zero_last) begin
               state_in = reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_CELL_RD: begin
            cmd.rd_sel = lla_pkg::RD_COORD;
            if (stat.in_range) begin
               state_in = S_CELL_WR;
            end else begin
               cmd.flag_range = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_CELL_WR: begin
            cmd.cell_finish = 1'b1;
            state_in        = S_DONE;
         end
         S_ADV_LAST: begin
            cmd.rd_sel = lla_pkg::RD_LAST;
            state_in   = S_ADV_FIRST;
         end
         S_ADV_FIRST: begin
            cmd.load_prev = 1'b1;
            cmd.rd_sel    = lla_pkg::RD_FIRST;
            state_in      = S_ADV_PRIME;
         end
         S_ADV_PRIME: begin
            cmd.load_first = 1'b1;
            cmd.rd_sel     = lla_pkg::RD_SECOND;
            state_in       = S_ADV_ROW;
         end
         S_ADV_ROW: begin
            cmd.row_step = 1'b1;
            cmd.rd_sel   = lla_pkg::RD_AHEAD;
            cmd.cnt_inc  = 1'b1;
            if (stat.row_last) begin
               state_in = stat.rows_full ? S_DONE : S_ZERO;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ZERO_START;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

endmodule

// ===== sv/life_like_automaton_step_unit.sv =====
// channel   direction  handshake                   payload
// req       in         req_valid / req_ready       req_op, req_row, req_col
// rsp       out        rsp_valid / rsp_ready       rsp_cell_alive, rsp_status
// csr       in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// set and read pass S_CELL_RD, S_CELL_WR and S_DONE, out of range skipping S_CELL_WR;
// clear zeroes one row of storage per cycle through the single write port, then S_DONE.
// a generation fetches the wrap rows in S_ADV_LAST, S_ADV_FIRST and S_ADV_PRIME, updates
// the rows in use in S_ADV_ROW and zeroes the rest of storage in the same pass.
// after reset a clearing pass comes before the first transaction;
// a stalled response waits in its output register and holds the next request in flight.
module life_like_automaton_step_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [5:0]                   req_row,
   input  logic [5:0]                   req_col,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_cell_alive,
   output logic                         rsp_status,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lla_pkg::PADDR_W-1:0]  paddr,
   input  logic [lla_pkg::PDATA_W-1:0]  pwdata,
   output logic [lla_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   lla_pkg::cfg_type  cfg;
   lla_pkg::cmd_type  cmd;
   lla_pkg::stat_type stat;

   // configuration registers
   lla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   lla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd)
   );

   // grid memory and row update
   lla_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_col        (req_col),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== tb/life_like_automaton_step_checker.sv =====
module life_like_automaton_step_checker
   import lla_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [5:0]           req_row,
   input  logic [5:0]           req_col,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_cell_alive,
   input  logic                 rsp_status,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic                 pready,
   input  logic [PADDR_W-1:0]   paddr,
   input  logic [PDATA_W-1:0]   pwdata,
   output int                   pending_results,
   output int                   responses_checked,
   output int                   mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_ROWS = 64;
   localparam int GRID_COLS = 64;

   typedef struct packed {
      logic cell_alive;
      logic status;
   } cell_result_type;

   // shadow of the grid and of the register file
   logic [63:0]  cells [GRID_ROWS];
   logic [8:0]   birth_rule;
   logic [8:0]   survive_rule;
   logic [6:0]   rows_reg;
   logic [6:0]   cols_reg;

   cell_result_type expected_q [$];
   cell_result_type oldest;
   cell_result_type fresh;
   int              mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // size registers saturate to the physical grid
   function automatic int used_rows();
      if (rows_reg == 7'd0) return 1;
      if (int'(rows_reg) > GRID_ROWS) return GRID_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic int used_cols();
      if (cols_reg == 7'd0) return 1;
      if (int'(cols_reg) > GRID_COLS) return GRID_COLS;
      return int'(cols_reg);
   endfunction

   function automatic void clear_grid();
      for (int r = 0; r < GRID_ROWS; r++)
         cells[r] = '0;
   endfunction

   // simultaneous update on the wrapped in-use area, everything else dies
   function automatic void run_generation();
      logic [63:0] old_cells [GRID_ROWS];
      logic [8:0]  rule;
      int          nr, nc, up, dn, lf, rt, cnt;
      old_cells = cells;
      nr = used_rows();
      nc = used_cols();
      clear_grid();
      for (int r = 0; r < nr; r++) begin
         up = (r + nr - 1) % nr;
         dn = (r + 1) % nr;
         for (int c = 0; c < nc; c++) begin
            lf = (c + nc - 1) % nc;
            rt = (c + 1) % nc;
            cnt = int'(old_cells[up][lf]) + int'(old_cells[up][c]) + int'(old_cells[up][rt])
                + int'(old_cells[r][lf]) + int'(old_cells[r][rt])
                + int'(old_cells[dn][lf]) + int'(old_cells[dn][c]) + int'(old_cells[dn][rt]);
            rule = old_cells[r][c] ? survive_rule : birth_rule;
            cells[r][c] = rule[cnt];
         end
      end
   endfunction

   // apply one request to the shadow grid and give its response
   function automatic cell_result_type predict_response(input logic [1:0] op,
                                                        input logic [5:0] row,
                                                        input logic [5:0] col);
      cell_result_type res;
      res = '0;
      case (op)
         OP_SET, OP_READ: begin
            if (int'(row) >= used_rows() || int'(col) >= used_cols())
               res.status = 1'b1;
            else if (op == OP_SET)
               cells[row][col] = 1'b1;
            else
               res.cell_alive = cells[row][col];
         end
         OP_ADVANCE: run_generation();
         OP_CLEAR:   clear_grid();
         default: ;
      endcase
      return res;
   endfunction

   function automatic void write_register(input logic [1:0] index,
                                          input logic [PDATA_W-1:0] value);
      case (index)
         REG_BIRTH_MASK:    birth_rule   = value[8:0];
         REG_SURVIVAL_MASK: survive_rule = value[8:0];
         REG_ROWS_IN_USE:   rows_reg     = value[6:0];
         REG_COLS_IN_USE:   cols_reg     = value[6:0];
         default: ;
      endcase
   endfunction

   // watch the channels on each rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_grid();
         birth_rule   = 9'd8;
         survive_rule = 9'd12;
         rows_reg     = 7'd64;
         cols_reg     = 7'd64;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready)
            write_register(paddr[3:2], pwdata);
         // responses first, so a stray one is never matched to a new request
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding (alive %b status %b)",
                                         rsp_cell_alive, rsp_status));
            end else begin
               oldest = expected_q.pop_front();
               responses_checked++;
               if (rsp_cell_alive !== oldest.cell_alive)
                  report_mismatch($sformatf("response %0d cell_alive %b expected %b",
                                            responses_checked, rsp_cell_alive,
                                            oldest.cell_alive));
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("response %0d status %b expected %b",
                                            responses_checked, rsp_status, oldest.status));
            end
         end
         if (req_valid && req_ready) begin
            fresh = predict_response(req_op, req_row, req_col);
            expected_q.push_back(fresh);
         end
      end
      pending_results <= expected_q.size();
   end

endmodule

// ===== tb/life_like_automaton_step_unit_tb.sv =====
module life_like_automaton_step_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lla_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 6;
   localparam int DRAIN        = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op = OP_SET;
   logic [5:0]          req_row = '0;
   logic [5:0]          req_col = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_cell_alive;
   logic                rsp_status;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   int   pending_results;
   int   responses_checked;
   int   mismatch_count;

   // stimulus state; calm and hold_rsp are shared with the response sink
   bit   calm = 1'b0;
   bit   hold_rsp = 1'b0;
   int   eff_rows = 64;
   int   eff_cols = 64;
   int   items_sent = 0;
   int   settings_count = 0;
   int   op_total [4] = '{0, 0, 0, 0};

   life_like_automaton_step_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_col        (req_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_alive (rsp_cell_alive),
      .rsp_status     (rsp_status),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   life_like_automaton_step_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_row           (req_row),
      .req_col           (req_col),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_alive    (rsp_cell_alive),
      .rsp_status        (rsp_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pending_results   (pending_results),
      .responses_checked (responses_checked),
      .mismatch_count    (mismatch_count)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one request transaction, keeping valid high across back-to-back items
   task automatic send_request(input logic [1:0] op, input logic [5:0] row,
                               input logic [5:0] col);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_row   <= row;
      req_col   <= col;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      op_total[op]++;
   endtask

   // coordinate mostly inside the in-use area, sometimes anywhere
   task automatic draw_cell(output logic [5:0] row, output logic [5:0] col);
      if ($urandom_range(0, 7) == 0) begin
         row = 6'($urandom_range(0, 63));
         col = 6'($urandom_range(0, 63));
      end else begin
         row = 6'($urandom_range(0, eff_rows - 1));
         col = 6'($urandom_range(0, eff_cols - 1));
      end
   endtask

   task automatic send_noise();
      send_request(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)));
   endtask

   // drop valid and wait until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // idle the block, then load all four registers
   task automatic load_settings(input logic [8:0] birth, input logic [8:0] survive,
                                input logic [6:0] rows, input logic [6:0] cols);
      logic [31:0] junk;
      wait_idle();
      junk = $urandom;
      write_csr(REG_BIRTH_MASK,    {junk[31:9], birth});
      write_csr(REG_SURVIVAL_MASK, {junk[31:9], survive});
      write_csr(REG_ROWS_IN_USE,   {junk[31:7], rows});
      write_csr(REG_COLS_IN_USE,   {junk[31:7], cols});
      eff_rows = (rows == 7'd0) ? 1 : ((int'(rows) > 64) ? 64 : int'(rows));
      eff_cols = (cols == 7'd0) ? 1 : ((int'(cols) > 64) ? 64 : int'(cols));
      settings_count++;
   endtask

   // response sink with random stalls and one long hold-off
   initial begin : response_sink
      int gap;
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = calm ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [8:0] birth, survive;
      logic [6:0] rows, cols;
      logic [5:0] row, col;
      int         phase;
      int         random_start;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty grid, corner cells, wrap across both edges
      send_request(OP_READ, 6'd0, 6'd0);
      send_request(OP_SET, 6'd0, 6'd0);
      send_request(OP_SET, 6'd63, 6'd63);
      send_request(OP_READ, 6'd63, 6'd63);
      send_request(OP_READ, 6'd0, 6'd0);
      send_request(OP_READ, 6'd63, 6'd62);
      send_request(OP_CLEAR, 6'd63, 6'd63);
      send_request(OP_READ, 6'd63, 6'd63);
      // blinker straddling the column wrap on the top row
      send_request(OP_SET, 6'd0, 6'd63);
      send_request(OP_SET, 6'd0, 6'd0);
      send_request(OP_SET, 6'd0, 6'd1);
      send_request(OP_ADVANCE, 6'd0, 6'd0);
      send_request(OP_READ, 6'd63, 6'd0);
      send_request(OP_READ, 6'd1, 6'd0);
      send_request(OP_READ, 6'd0, 6'd63);
      send_request(OP_READ, 6'd0, 6'd0);
      send_request(OP_ADVANCE, 6'd63, 6'd63);
      send_request(OP_READ, 6'd0, 6'd63);

      // directed: coordinates at and beyond a reduced size
      load_settings(9'd8, 9'd12, 7'd5, 7'd7);
      send_request(OP_SET, 6'd5, 6'd0);
      send_request(OP_READ, 6'd0, 6'd7);
      send_request(OP_SET, 6'd63, 6'd63);
      send_request(OP_READ, 6'd4, 6'd6);
      send_request(OP_SET, 6'd4, 6'd6);
      send_request(OP_READ, 6'd4, 6'd6);
      send_request(OP_ADVANCE, 6'd0, 6'd0);
      send_request(OP_READ, 6'd4, 6'd6);

      // random phases: configure, seed, run generations, sample cells
      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         case (phase)
            0: begin birth = 9'd0;   survive = 9'd0;   rows = 7'd1;   cols = 7'd1;   end
            1: begin birth = 9'h1FF; survive = 9'h1FF; rows = 7'd64;  cols = 7'd64;  end
            2: begin birth = 9'd8;   survive = 9'd12;  rows = 7'd0;   cols = 7'd0;   end
            3: begin birth = 9'd8;   survive = 9'd12;  rows = 7'd127; cols = 7'd127; end
            4: begin
               birth = 9'($urandom_range(0, 511));
               survive = 9'($urandom_range(0, 511));
               rows = 7'd2;
               cols = 7'd2;
            end
            default: begin
               if ($urandom_range(0, 2) == 0) begin
                  birth = 9'd8;
                  survive = 9'd12;
               end else begin
                  birth = 9'($urandom_range(0, 511));
                  survive = 9'($urandom_range(0, 511));
               end
               rows = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 12))
                                                 : 7'($urandom_range(0, 127));
               cols = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 12))
                                                 : 7'($urandom_range(0, 127));
            end
         endcase
         load_settings(birth, survive, rows, cols);
         calm = (phase % 4 == 3);
         if (phase == 5)
            hold_rsp = 1'b1;

         // usually start clean, sometimes keep the old pattern
         if ($urandom_range(0, 4) != 0)
            send_request(OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         repeat ($urandom_range(1, 16)) begin
            if ($urandom_range(0, 9) == 0) begin
               send_noise();
            end else begin
               draw_cell(row, col);
               send_request(OP_SET, row, col);
            end
         end
         repeat ($urandom_range(2, 6)) begin
            send_request(OP_ADVANCE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            repeat ($urandom_range(6, 10)) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_noise();
               end else begin
                  draw_cell(row, col);
                  send_request(OP_READ, row, col);
               end
            end
         end
         phase++;
      end

      // drain
      calm = 1'b0;
      wait_idle();
      repeat (DRAIN) @(posedge clock);

      $display("covered %0d request transactions over %0d register settings, %0d responses checked",
               items_sent, settings_count, responses_checked);
      $display("by operation: set %0d, advance %0d, read %0d, clear %0d",
               op_total[OP_SET], op_total[OP_ADVANCE], op_total[OP_READ], op_total[OP_CLEAR]);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lla_pkg.sv
sv/lla_csr.sv
sv/lla_datapath.sv
sv/lla_ctrl.sv
sv/life_like_automaton_step_unit.sv
tb/life_like_automaton_step_checker.sv
tb/life_like_automaton_step_unit_tb.sv
